// ----- hw/rtl/ipv4rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: shared definitions
// Verdict codes, register indexes, queue sizing and the per-packet record
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package ipv4rhc_pkg;

  // Number of protocol slots in the default build.
  localparam int unsigned ProtocolSlotsDefault = 4;

  // Configuration data is as wide as the widest register, the local address.
  localparam int unsigned CfgDataW = 32;

  // Register indexes of the configuration port.
  localparam int unsigned CfgLocalAddr  = 0;
  localparam int unsigned CfgSlotEnable = 1;
  localparam int unsigned CfgSlotProto0 = 2;

  // Entries in the queue between front end and back end.
  localparam int unsigned QueueDepth = 2;

  // Smallest legal header length in 32-bit words.
  localparam logic [3:0] MinHeaderWords = 4'd5;
  // Version nibble that is turned away.
  localparam logic [3:0] Ipv6Version = 4'd6;

  typedef enum logic [2:0] {
    StAccept    = 3'd0,
    StIpv6      = 3'd1,
    StBadIhl    = 3'd2,
    StShort     = 3'd3,
    StWrongDst  = 3'd4,
    StBadSum    = 3'd5,
    StNoHandler = 3'd6
  } status_e;

  // Everything the back end needs to judge one finished packet.
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [15:0] sum;
    logic [15:0] rx_csum;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] pkt_len;
  } hdr_rec_t;

endpackage

// ----- hw/rtl/ipv4rhc_in_if.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: byte input channel
// Valid/ready channel carrying one packet byte and its last flag per word.
// ----------------------------------------------------------------------------
interface ipv4rhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/ipv4rhc_out_if.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: verdict output channel
// Valid/ready channel carrying one packet verdict per word.
// ----------------------------------------------------------------------------
interface ipv4rhc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [5:0]  header_bytes;
  logic [15:0] payload_bytes;

  modport source (output valid, output status, output protocol, output source_address,
                  output header_bytes, output payload_bytes, input ready);
  modport sink   (input valid, input status, input protocol, input source_address,
                  input header_bytes, input payload_bytes, output ready);
endinterface

// ----- hw/rtl/ipv4rhc_front.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: front end
// Follows the byte stream, captures header fields and keeps the running
// ones' complement sum; emits a packet record on the last byte.
// ----------------------------------------------------------------------------
module ipv4rhc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output ipv4rhc_pkg::hdr_rec_t rec_o
);
  import ipv4rhc_pkg::*;

  localparam logic [15:0] PosMax    = 16'hFFFF;
  localparam logic [15:0] PosProto  = 16'd9;
  localparam logic [15:0] PosCsumHi = 16'd10;
  localparam logic [15:0] PosCsumLo = 16'd11;
  localparam logic [15:0] PosSrcLo  = 16'd12;
  localparam logic [15:0] PosSrcHi  = 16'd15;
  localparam logic [15:0] PosDstLo  = 16'd16;
  localparam logic [15:0] PosDstHi  = 16'd19;

  logic [15:0] pos_q, pos_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic [15:0] rxsum_q, rxsum_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic        accept;
  logic [5:0]  hdr_len;
  logic [7:0]  sum_byte;
  logic [16:0] raw_sum;
  logic [15:0] folded_sum;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  assign hdr_len  = (pos_q == '0) ? {data_byte_i[3:0], 2'b00} : {first_q[3:0], 2'b00};
  assign sum_byte = (pos_q == PosCsumHi || pos_q == PosCsumLo) ? 8'h00 : data_byte_i;

  // End-around carry: the fold cannot carry out again.
  assign raw_sum    = {1'b0, sum_q} + {1'b0, pend_q, sum_byte};
  assign folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

  always_comb begin
    first_d = first_q;
    proto_d = proto_q;
    rxsum_d = rxsum_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pend_d  = pend_q;
    sum_d   = sum_q;
    if (pos_q == '0) begin
      first_d = data_byte_i;
    end
    if (pos_q == PosProto) begin
      proto_d = data_byte_i;
    end
    if (pos_q == PosCsumHi) begin
      rxsum_d = {data_byte_i, 8'h00};
    end
    if (pos_q == PosCsumLo) begin
      rxsum_d = {rxsum_q[15:8], data_byte_i};
    end
    if (pos_q >= PosSrcLo && pos_q <= PosSrcHi) begin
      src_d = {src_q[23:0], data_byte_i};
    end
    if (pos_q >= PosDstLo && pos_q <= PosDstHi) begin
      dst_d = {dst_q[23:0], data_byte_i};
    end
    if (pos_q < {10'd0, hdr_len}) begin
      if (!pos_q[0]) begin
        pend_d = sum_byte;
      end else begin
        sum_d = folded_sum;
      end
    end
    pos_d = (pos_q == PosMax) ? PosMax : pos_q + 16'd1;
  end

  assign push_o           = accept & last_byte_i;
  assign rec_o.first_byte = first_d;
  assign rec_o.sum        = sum_d;
  assign rec_o.rx_csum    = rxsum_d;
  assign rec_o.protocol   = proto_d;
  assign rec_o.src_addr   = src_d;
  assign rec_o.dst_addr   = dst_d;
  assign rec_o.pkt_len    = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= '0;
      sum_q   <= '0;
      pend_q  <= '0;
      rxsum_q <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        first_q <= '0;
        sum_q   <= '0;
        pend_q  <= '0;
        rxsum_q <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        first_q <= first_d;
        sum_q   <= sum_d;
        pend_q  <= pend_d;
        rxsum_q <= rxsum_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
      end
    end
  end

endmodule

// ----- hw/rtl/ipv4rhc_fifo.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: record queue
// Short first-in first-out queue of packet records between the two ends.
// ----------------------------------------------------------------------------
module ipv4rhc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ipv4rhc_pkg::hdr_rec_t wdata_i,
  input  logic                  pop_i,
  output ipv4rhc_pkg::hdr_rec_t rdata_o,
  output logic                  valid_o,
  output logic                  full_o
);
  import ipv4rhc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  hdr_rec_t          mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/ipv4rhc_back.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: back end
// Judges each packet record against the configuration and holds the verdict
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module ipv4rhc_back #(
  parameter int unsigned ProtocolSlots = ipv4rhc_pkg::ProtocolSlotsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ipv4rhc_pkg::hdr_rec_t    rec_i,
  input  logic                     rec_valid_i,
  output logic                     pop_o,
  input  logic [31:0]              local_addr_i,
  input  logic [ProtocolSlots-1:0] slot_enable_i,
  input  logic [7:0]               slot_proto_i [ProtocolSlots],
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic [7:0]               protocol_o,
  output logic [31:0]              source_address_o,
  output logic [5:0]               header_bytes_o,
  output logic [15:0]              payload_bytes_o
);
  import ipv4rhc_pkg::*;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [7:0]  protocol_q;
  logic [31:0] src_q;
  logic [5:0]  hdr_q;
  logic [15:0] payload_q;

  logic        load;
  logic        handler_hit;
  logic [5:0]  hdr_len;
  status_e     status;

  assign hdr_len = {rec_i.first_byte[3:0], 2'b00};

  always_comb begin
    handler_hit = 1'b0;
    for (int i = 0; i < ProtocolSlots; i++) begin
      if (slot_enable_i[i] && slot_proto_i[i] == rec_i.protocol) begin
        handler_hit = 1'b1;
      end
    end
  end

  // The checks are ranked: the first one that fails names the verdict.
  always_comb begin
    if (rec_i.first_byte[7:4] == Ipv6Version) begin
      status = StIpv6;
    end else if (rec_i.first_byte[3:0] < MinHeaderWords) begin
      status = StBadIhl;
    end else if ({10'd0, hdr_len} > rec_i.pkt_len) begin
      status = StShort;
    end else if (rec_i.dst_addr != local_addr_i) begin
      status = StWrongDst;
    end else if (~rec_i.sum != rec_i.rx_csum) begin
      status = StBadSum;
    end else if (!handler_hit) begin
      status = StNoHandler;
    end else begin
      status = StAccept;
    end
  end

  assign load  = rec_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status;
      if (status == StAccept) begin
        protocol_q <= rec_i.protocol;
        src_q      <= rec_i.src_addr;
        hdr_q      <= hdr_len;
        payload_q  <= rec_i.pkt_len - {10'd0, hdr_len};
      end else begin
        protocol_q <= '0;
        src_q      <= '0;
        hdr_q      <= '0;
        payload_q  <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign protocol_o       = protocol_q;
  assign source_address_o = src_q;
  assign header_bytes_o   = hdr_q;
  assign payload_bytes_o  = payload_q;

endmodule

// ----- hw/rtl/ipv4_receive_header_check_top.sv -----
// ----------------------------------------------------------------------------
// IPv4 receive header check: top level
// Streams IPv4 packets byte by byte and issues one verdict per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock cycle, header first, with the
// last flag set on the final byte, and gives exactly one verdict word per
// packet. Input words are taken at full rate: the input is only held off
// when the two-entry record queue is full, which can happen only while the
// verdict output is stalled. Once the final byte is accepted, its record is
// written into the queue, and the back end's judgement of it is then loaded
// into the output register once it has room. Checks are ranked as follows,
// and the first to fail gives the status: version six, a header length of
// fewer than five words, a packet shorter than its header, a destination
// other than the local address, a header checksum mismatch, and a protocol
// not served by any enabled slot. Only an accepted packet carries protocol,
// source address, header length and payload length; a rejected one has
// them at zero. The packet length counter saturates at 65535 bytes.
// Configuration registers should be written only while no packet is in
// flight.
// ----------------------------------------------------------------------------
module ipv4_receive_header_check_top #(
  parameter int unsigned ProtocolSlots = ipv4rhc_pkg::ProtocolSlotsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [$clog2(2 + ProtocolSlots)-1:0]  cfg_idx_i,
  input  logic [ipv4rhc_pkg::CfgDataW-1:0]      cfg_data_i,
  ipv4rhc_in_if.sink                            rx_i,
  ipv4rhc_out_if.source                         verdict_o
);
  import ipv4rhc_pkg::*;

  localparam int unsigned CfgIdxW = $clog2(2 + ProtocolSlots);

  // Configuration registers. Writes to indexes beyond the slot registers
  // fall through every compare below and are therefore ignored.
  logic [31:0]              local_addr_q;
  logic [ProtocolSlots-1:0] slot_enable_q;
  logic [7:0]               slot_proto_q [ProtocolSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q  <= '0;
      slot_enable_q <= '0;
      for (int i = 0; i < ProtocolSlots; i++) begin
        slot_proto_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxW'(CfgLocalAddr)) begin
        local_addr_q <= cfg_data_i[31:0];
      end
      if (cfg_idx_i == CfgIdxW'(CfgSlotEnable)) begin
        slot_enable_q <= cfg_data_i[ProtocolSlots-1:0];
      end
      for (int i = 0; i < ProtocolSlots; i++) begin
        if (cfg_idx_i == CfgIdxW'(CfgSlotProto0 + i)) begin
          slot_proto_q[i] <= cfg_data_i[7:0];
        end
      end
    end
  end

  // The front end follows the byte stream; a finished packet becomes one
  // record, which waits in the queue until the back end has room for it.
  hdr_rec_t push_rec;
  hdr_rec_t head_rec;
  logic     push;
  logic     pop;
  logic     head_valid;
  logic     queue_full;

  ipv4rhc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rx_i.valid),
    .in_ready_o   (rx_i.ready),
    .data_byte_i  (rx_i.data_byte),
    .last_byte_i  (rx_i.last_byte),
    .queue_full_i (queue_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  ipv4rhc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (head_rec),
    .valid_o (head_valid),
    .full_o  (queue_full)
  );

  // The back end judges the record at the head of the queue and keeps the
  // verdict in its output register until the sink takes it.
  ipv4rhc_back #(
    .ProtocolSlots (ProtocolSlots)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_i            (head_rec),
    .rec_valid_i      (head_valid),
    .pop_o            (pop),
    .local_addr_i     (local_addr_q),
    .slot_enable_i    (slot_enable_q),
    .slot_proto_i     (slot_proto_q),
    .out_valid_o      (verdict_o.valid),
    .out_ready_i      (verdict_o.ready),
    .status_o         (verdict_o.status),
    .protocol_o       (verdict_o.protocol),
    .source_address_o (verdict_o.source_address),
    .header_bytes_o   (verdict_o.header_bytes),
    .payload_bytes_o  (verdict_o.payload_bytes)
  );

endmodule
